@@ hw/rtl/day_count_calendar_convert_top_assert.svh @@
// Assertion macros for the day count converter
`ifndef DAY_COUNT_CALENDAR_CONVERT_TOP_ASSERT_SVH
`define DAY_COUNT_CALENDAR_CONVERT_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define DCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define DCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dcc_pkg.sv @@
package dcc_pkg;

  localparam int unsigned FirstYear = 1978;
  localparam int unsigned FinalYear = 2077;
  localparam int unsigned MaxCount  = 36525;
  localparam int unsigned NumStages = 4;

  typedef enum logic {
    MODE_TO_DATE  = 1'b0,
    MODE_TO_COUNT = 1'b1
  } mode_e;

  // Days before the start of a year, offset in years from 1978 (0..99)
  function automatic logic [15:0] year_start(input logic [6:0] yo);
    logic [15:0] y;
    y = 16'(yo);
    return 16'(y * 16'd365) + 16'((y + 16'd1) >> 2);
  endfunction

  // Days before the first of a month (1..12)
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && m > 4'd2) s = s + 9'd1;
    return s;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] l;
    case (m)
      4'd2:                      l = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
      default:                   l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

@@ hw/rtl/dcc_pipe.sv @@
// Four-stage conversion datapath with per-stage valid and stall
module dcc_pipe (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] day_count_in_i,
  input  logic [11:0] year_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  dom_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [15:0] day_count_out_o,
  output logic [11:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  dom_out_o,
  output logic [2:0]  weekday_o
);
  import dcc_pkg::*;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  // Stall chain: a stage moves when the next one is free
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < NumStages; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Stage 1: range checks, year offset estimate, weekday
  logic        m1_q, ok1_q;
  logic [15:0] cnt1_q;
  logic [6:0]  yo1_q;
  logic [3:0]  mon1_q;
  logic [4:0]  dom1_q;
  logic [2:0]  wd1_q;
  logic [15:0] cm1;
  logic [6:0]  yest;
  logic [11:0] yo_full;
  logic [5:0]  wsum;
  logic [3:0]  wfold;
  logic [3:0]  wred;
  logic [2:0]  wd1;

  // Estimate never exceeds the true year offset and is at most one low
  always_comb begin
    cm1     = day_count_in_i - 16'd1;
    yest    = 7'((32'(cm1) * 32'd2870) >> 20);
    yo_full = year_in_i - 12'(FirstYear);
  end

  // Weekday: mod 7 by folding octal digits, since 8 = 1 mod 7
  always_comb begin
    wsum  = 6'(cm1[2:0]) + 6'(cm1[5:3]) + 6'(cm1[8:6]) + 6'(cm1[11:9])
            + 6'(cm1[14:12]) + 6'(cm1[15]);
    wfold = 4'(wsum[2:0]) + 4'(wsum[5:3]);
    wred  = 4'(wfold[2:0]) + 4'(wfold[3]);
    wd1   = (wred >= 4'd7) ? 3'(wred - 4'd7) : wred[2:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      m1_q   <= mode_i;
      cnt1_q <= day_count_in_i;
      mon1_q <= month_in_i;
      dom1_q <= dom_in_i;
      wd1_q  <= wd1;
      if (mode_i == MODE_TO_COUNT) begin
        yo1_q <= yo_full[6:0];
        ok1_q <= year_in_i >= 12'(FirstYear) && year_in_i <= 12'(FinalYear)
                 && month_in_i >= 4'd1 && month_in_i <= 4'd12 && dom_in_i != 5'd0;
      end else begin
        yo1_q <= yest;
        ok1_q <= day_count_in_i != 16'd0 && day_count_in_i <= 16'(MaxCount);
      end
    end
  end

  // Stage 2: correct year estimate, day of year (to-date) or year start (to-count)
  logic        m2_q, ok2_q, lp2_q;
  logic [15:0] acc2_q;
  logic [6:0]  yo2_q;
  logic [3:0]  mon2_q;
  logic [4:0]  dom2_q;
  logic [2:0]  wd2_q;
  logic [15:0] ys_a, ys_b;
  logic [6:0]  yo2;

  always_comb begin
    ys_a = year_start(yo1_q);
    ys_b = year_start(yo1_q + 7'd1);
    yo2  = yo1_q;
    if (m1_q == MODE_TO_DATE && yo1_q < 7'd99 && cnt1_q > ys_b) yo2 = yo1_q + 7'd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      m2_q   <= m1_q;
      ok2_q  <= ok1_q;
      yo2_q  <= yo2;
      lp2_q  <= yo2[1:0] == 2'd2;
      mon2_q <= mon1_q;
      dom2_q <= dom1_q;
      wd2_q  <= wd1_q;
      if (m1_q == MODE_TO_COUNT) acc2_q <= ys_a;
      else acc2_q <= cnt1_q - ((yo2 != yo1_q) ? ys_b : ys_a);
    end
  end

  // Stage 3: month search over day of year, or month length check and count sum
  logic        m3_q, ok3_q;
  logic [15:0] acc3_q;
  logic [6:0]  yo3_q;
  logic [3:0]  mon3_q;
  logic [4:0]  dom3_q;
  logic [2:0]  wd3_q;
  logic [3:0]  msel;

  always_comb begin
    msel = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (acc2_q[8:0] > month_start(4'(k), lp2_q)) msel = 4'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      m3_q  <= m2_q;
      yo3_q <= yo2_q;
      wd3_q <= wd2_q;
      if (m2_q == MODE_TO_COUNT) begin
        ok3_q  <= ok2_q && dom2_q <= month_len(mon2_q, lp2_q);
        acc3_q <= acc2_q + 16'(month_start(mon2_q, lp2_q)) + 16'(dom2_q);
        mon3_q <= mon2_q;
        dom3_q <= dom2_q;
      end else begin
        ok3_q  <= ok2_q;
        acc3_q <= acc2_q;
        mon3_q <= msel;
        dom3_q <= 5'(acc2_q[8:0] - month_start(msel, lp2_q));
      end
    end
  end

  // Stage 4: output register, invalid or unused fields zeroed
  logic        vr_q;
  logic [15:0] dc_q;
  logic [11:0] yr_q;
  logic [3:0]  mo_q;
  logic [4:0]  dm_q;
  logic [2:0]  wd_q;
  logic        to_date;

  assign to_date = ok3_q && m3_q == MODE_TO_DATE;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      vr_q <= ok3_q;
      dc_q <= (ok3_q && m3_q == MODE_TO_COUNT) ? acc3_q : 16'd0;
      yr_q <= to_date ? 12'(FirstYear) + 12'(yo3_q) : 12'd0;
      mo_q <= to_date ? mon3_q : 4'd0;
      dm_q <= to_date ? dom3_q : 5'd0;
      wd_q <= to_date ? wd3_q : 3'd0;
    end
  end

  assign out_valid_o     = vld_q[NumStages-1];
  assign valid_res_o     = vr_q;
  assign day_count_out_o = dc_q;
  assign year_out_o      = yr_q;
  assign month_out_o     = mo_q;
  assign dom_out_o       = dm_q;
  assign weekday_o       = wd_q;
endmodule

@@ hw/rtl/day_count_calendar_convert_top.sv @@
// Four register stages; the year estimate and month search are pipelined.
// Throughput: one item per cycle while the output is not stalled.
// A stalled output holds the full stages in place; bubbles ahead of them still fill.
// Reset (rst_ni low, async) clears all stage valid bits; no clearing pass.
module day_count_calendar_convert_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] day_count_in_i,
  input  logic [11:0] year_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  dom_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [15:0] day_count_out_o,
  output logic [11:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  dom_out_o,
  output logic [2:0]  weekday_o
);
  import dcc_pkg::*;
  `include "day_count_calendar_convert_top_assert.svh"

  dcc_pipe u_pipe (.*);

  // Stalled result holds; invalid results are zeroed; date fields are in range
  `DCC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(day_count_out_o) && $stable(year_out_o),
    "stalled result changed")
  `DCC_ASSERT_IMP(a_zero, clk_i, rst_ni, out_valid_o && !valid_res_o,
    day_count_out_o == 16'd0 && year_out_o == 12'd0 && weekday_o == 3'd0,
    "invalid result not zeroed")
  `DCC_ASSERT_IMP(a_range, clk_i, rst_ni, out_valid_o && year_out_o != 12'd0,
    month_out_o >= 4'd1 && month_out_o <= 4'd12 && dom_out_o != 5'd0 && weekday_o <= 3'd6,
    "date out of range")
endmodule

@@ bench/dcc_checker.sv @@
`timescale 1ns / 1ps

module dcc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [15:0] day_count_in_i,
  input  logic [11:0] year_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  dom_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        valid_res_i,
  input  logic [15:0] day_count_out_i,
  input  logic [11:0] year_out_i,
  input  logic [3:0]  month_out_i,
  input  logic [4:0]  dom_out_i,
  input  logic [2:0]  weekday_i,
  output int          errors_o,
  output int          pending_o,
  output int          converted_o,
  output int          rejected_o
);
  import dcc_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [15:0] count;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [2:0]  wday;
  } date_res_t;

  date_res_t expected_dates[$];

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned lens[12];
    lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && (y % 4) == 0) return 29;
    return lens[m - 1];
  endfunction

  function automatic int unsigned days_in_year(int unsigned y);
    return ((y % 4) == 0) ? 366 : 365;
  endfunction

  // Calendar walk in both directions
  function automatic date_res_t convert_date(logic md, logic [15:0] cnt, logic [11:0] yi,
                                             logic [3:0] mi, logic [4:0] di);
    date_res_t   r;
    int unsigned n, y, m;
    r = '0;
    if (mode_e'(md) == MODE_TO_DATE) begin
      if (cnt == 0 || cnt > MaxCount) return r;
      n = cnt;
      y = FirstYear;
      m = 1;
      while (n > days_in_year(y)) begin
        n -= days_in_year(y);
        y++;
      end
      while (m < 12 && n > days_in_month(m, y)) begin
        n -= days_in_month(m, y);
        m++;
      end
      r.ok = 1'b1;
      r.year = 12'(y);
      r.month = 4'(m);
      r.dom = 5'(n);
      r.wday = 3'((cnt - 1) % 7);
    end else begin
      if (yi < FirstYear || yi > FinalYear || mi < 1 || mi > 12) return r;
      if (di < 1 || di > days_in_month(mi, yi)) return r;
      n = 0;
      for (y = FirstYear; y < yi; y++) n += days_in_year(y);
      for (m = 1; m < mi; m++) n += days_in_month(m, yi);
      r.ok = 1'b1;
      r.count = 16'(n + di);
    end
    return r;
  endfunction

  assign pending_o = expected_dates.size();

  // Predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    date_res_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_dates.push_back(convert_date(mode_i, day_count_in_i, year_in_i,
                                              month_in_i, dom_in_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result, nothing pending", $time);
          errors_o++;
        end else begin
          e = expected_dates.pop_front();
          if (e.ok) converted_o++; else rejected_o++;
          if (e.ok !== valid_res_i || e.count !== day_count_out_i ||
              e.year !== year_out_i || e.month !== month_out_i ||
              e.dom !== dom_out_i || e.wday !== weekday_i) begin
            $display("%0t: mismatch exp ok=%0d cnt=%0d %0d-%0d-%0d wd=%0d", $time,
                     e.ok, e.count, e.year, e.month, e.dom, e.wday);
            $display("%0t:          act ok=%0d cnt=%0d %0d-%0d-%0d wd=%0d", $time,
                     valid_res_i, day_count_out_i, year_out_i, month_out_i,
                     dom_out_i, weekday_i);
            errors_o++;
          end
        end
      end
    end
  end

  initial begin
    errors_o = 0;
    converted_o = 0;
    rejected_o = 0;
  end
endmodule

@@ bench/tb_day_count_calendar_convert_top.sv @@
`timescale 1ns / 1ps

module tb_day_count_calendar_convert_top;
  import dcc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = 1'b0;
  logic [15:0] day_count_in_i = '0;
  logic [11:0] year_in_i = '0;
  logic [3:0]  month_in_i = '0;
  logic [4:0]  dom_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        valid_res_o;
  logic [15:0] day_count_out_o;
  logic [11:0] year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  dom_out_o;
  logic [2:0]  weekday_o;
  int          errors, pending, converted, rejected;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;

  always #10 clk_i = ~clk_i;

  day_count_calendar_convert_top dut (.*);

  dcc_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .day_count_in_i,
    .year_in_i, .month_in_i, .dom_in_i, .out_valid_i(out_valid_o), .out_ready_i,
    .valid_res_i(valid_res_o), .day_count_out_i(day_count_out_o),
    .year_out_i(year_out_o), .month_out_i(month_out_o), .dom_out_i(dom_out_o),
    .weekday_i(weekday_o), .errors_o(errors), .pending_o(pending),
    .converted_o(converted), .rejected_o(rejected)
  );

  // Receiver: random stalls, or a long counted hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item and wait until accepted; valid drops only while idling
  task automatic send_item(logic md, logic [15:0] cnt, logic [11:0] yr,
                           logic [3:0] mo, logic [4:0] dd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    day_count_in_i <= cnt;
    year_in_i <= yr;
    month_in_i <= mo;
    dom_in_i <= dd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random;
    int unsigned k;
    k = $urandom_range(9);
    if (k < 4) begin
      send_item(MODE_TO_DATE, 16'($urandom_range(MaxCount, 1)), 12'($urandom),
                4'($urandom), 5'($urandom));
    end else if (k < 8) begin
      send_item(MODE_TO_COUNT, 16'($urandom), 12'($urandom_range(FinalYear, FirstYear)),
                4'($urandom_range(12, 1)), 5'($urandom_range(31, 1)));
    end else if (k == 8) begin
      send_item(MODE_TO_DATE, 16'($urandom), 12'($urandom), 4'($urandom), 5'($urandom));
    end else begin
      send_item(MODE_TO_COUNT, 16'($urandom), 12'($urandom), 4'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    int cycles;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: edges of the range and bad fields
    send_item(MODE_TO_DATE, 16'd0, '0, '0, '0);
    send_item(MODE_TO_DATE, 16'd1, '0, '0, '0);
    send_item(MODE_TO_DATE, 16'd365, '0, '0, '0);
    send_item(MODE_TO_DATE, 16'd366, '0, '0, '0);
    send_item(MODE_TO_DATE, 16'd790, '0, '0, '0);
    send_item(MODE_TO_DATE, 16'd8096, '0, '0, '0);
    send_item(MODE_TO_DATE, 16'(MaxCount), '0, '0, '0);
    send_item(MODE_TO_DATE, 16'(MaxCount + 1), '0, '0, '0);
    send_item(MODE_TO_DATE, 16'hFFFF, 12'hFFF, 4'hF, 5'h1F);
    send_item(MODE_TO_COUNT, 16'hFFFF, 12'd1978, 4'd1, 5'd1);
    send_item(MODE_TO_COUNT, '0, 12'd2077, 4'd12, 5'd31);
    send_item(MODE_TO_COUNT, '0, 12'd1977, 4'd12, 5'd31);
    send_item(MODE_TO_COUNT, '0, 12'd2078, 4'd1, 5'd1);
    send_item(MODE_TO_COUNT, '0, 12'hFFF, 4'hF, 5'h1F);
    send_item(MODE_TO_COUNT, '0, 12'd2000, 4'd0, 5'd1);
    send_item(MODE_TO_COUNT, '0, 12'd2000, 4'd13, 5'd1);
    send_item(MODE_TO_COUNT, '0, 12'd2000, 4'd5, 5'd0);
    send_item(MODE_TO_COUNT, '0, 12'd2000, 4'd2, 5'd29);
    send_item(MODE_TO_COUNT, '0, 12'd2001, 4'd2, 5'd29);
    send_item(MODE_TO_COUNT, '0, 12'd2001, 4'd4, 5'd31);
    send_item(MODE_TO_COUNT, '0, 12'd2001, 4'd4, 5'd30);

    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 46 : 35) : 0;
      recv_stall_pct = (ph == 2) ? 46 : ((ph == 3) ? 35 : 0);
      if (ph == 1) hold_off = 60;
      for (int i = 0; i < 400; i++) send_random();
    end
    in_valid_i <= 1'b0;

    recv_stall_pct = 0;
    cycles = 0;
    while (pending != 0 && cycles < 10000) begin
      @(posedge clk_i);
      cycles++;
    end
    repeat (20) @(posedge clk_i);
    $display("Ran directed edges and 1600 random items over four idling phases.");
    $display("Results: %0d valid conversions, %0d rejected inputs.", converted, rejected);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
